/* rtl/core/crg_pkg.sv */
// Shared types and constants for the camera ray generator.
package crg_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TAN_HALF_FOV = 3'd2;
  localparam logic [2:0] REG_ROT_ROW0     = 3'd3;
  localparam logic [2:0] REG_ROT_ROW1     = 3'd4;
  localparam logic [2:0] REG_ROT_ROW2     = 3'd5;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [19:0] RST_TAN_HALF_FOV = 20'd65536;
  localparam logic [47:0] RST_ROT_ROW0     = 48'h0000_0000_4000;
  localparam logic [47:0] RST_ROT_ROW1     = 48'h0000_4000_0000;
  localparam logic [47:0] RST_ROT_ROW2     = 48'h4000_0000_0000;

  // unit length in Q1.14
  localparam logic [14:0] DIR_ONE = 15'd16384;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } origin_t;

  typedef struct packed {
    logic [12:0]       image_width;
    logic [12:0]       image_height;
    logic [19:0]       tan_half_fov;
    logic [2:0][47:0]  rot;
  } cfg_t;

  // classified item: screen offsets in signed Q14.4 pixels, clamped height
  typedef struct packed {
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [12:0]        h;
    origin_t            org;
  } front_item_t;

  // world direction ready for normalizing
  typedef struct packed {
    logic [2:0][29:0] mag;
    logic [2:0]       neg;
    logic [61:0]      sum;
    origin_t          org;
  } dir_item_t;

endpackage

/* rtl/core/crg_regs.sv */
// Configuration register file with an APB-style port.
module crg_regs import crg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.tan_half_fov <= RST_TAN_HALF_FOV;
      cfg.rot[0]       <= RST_ROT_ROW0;
      cfg.rot[1]       <= RST_ROT_ROW1;
      cfg.rot[2]       <= RST_ROT_ROW2;
    end else if (wr) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[12:0];
        REG_TAN_HALF_FOV: cfg.tan_half_fov <= pwdata[19:0];
        REG_ROT_ROW0:     cfg.rot[0]       <= pwdata[47:0];
        REG_ROT_ROW1:     cfg.rot[1]       <= pwdata[47:0];
        REG_ROT_ROW2:     cfg.rot[2]       <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = {51'd0, cfg.image_width};
      REG_IMAGE_HEIGHT: prdata = {51'd0, cfg.image_height};
      REG_TAN_HALF_FOV: prdata = {44'd0, cfg.tan_half_fov};
      REG_ROT_ROW0:     prdata = {16'd0, cfg.rot[0]};
      REG_ROT_ROW1:     prdata = {16'd0, cfg.rot[1]};
      REG_ROT_ROW2:     prdata = {16'd0, cfg.rot[2]};
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/crg_front.sv */
// Front end: takes items, clamps image size, forms screen offsets.
module crg_front import crg_pkg::*; #(
  parameter int IMAGE_DIM_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [15:0] pixel_row,
  input  logic [15:0] pixel_col,
  input  origin_t     org,
  input  cfg_t        cfg,
  output logic        item_valid,
  output front_item_t item
);

  localparam logic [15:0] DIM_LIMIT = 16'(1 << IMAGE_DIM_BITS);

  logic [15:0] w_clamp;
  logic [15:0] h_clamp;

  always_comb begin
    w_clamp = {3'd0, cfg.image_width};
    h_clamp = {3'd0, cfg.image_height};
    if (w_clamp == 16'd0) w_clamp = 16'd1;
    if (h_clamp == 16'd0) h_clamp = 16'd1;
    if (w_clamp > DIM_LIMIT) w_clamp = DIM_LIMIT;
    if (h_clamp > DIM_LIMIT) h_clamp = DIM_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else     item_valid <= take;
  end

  // clamped size never exceeds the 13-bit register range
  always_ff @(posedge clk) begin
    if (take) begin
      item.dx  <= $signed({2'b00, pixel_col}) - $signed({2'b00, w_clamp[12:0], 3'b000});
      item.dy  <= $signed({2'b00, h_clamp[12:0], 3'b000}) - $signed({2'b00, pixel_row});
      item.h   <= h_clamp[12:0];
      item.org <= org;
    end
  end

endmodule

/* rtl/core/crg_fifo.sv */
// Two-entry queue between front end and datapath.
module crg_fifo import crg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        pop_valid,
  output front_item_t pop_item,
  output logic        full
);

  front_item_t mem [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = count != 2'd0;
  assign pop_valid = pop;
  assign pop_item  = mem[rptr];
  assign full      = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/core/crg_xform.sv */
// Datapath part one: screen vector, rotation, magnitude scaling, sum of squares.
module crg_xform import crg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  front_item_t in_item,
  input  cfg_t        cfg,
  output logic        out_valid,
  output dir_item_t   out_item
);

  logic [7:0] vld;

  // stage 1: screen vector scaled by 8*H*2^16
  logic signed [38:0] v [3];
  origin_t            o1;
  // stage 2: products
  logic signed [54:0] p [3][3];
  origin_t            o2;
  // stage 3: rotated vector
  logic signed [56:0] u [3];
  origin_t            o3;
  // stage 4: magnitudes
  logic [55:0]        mag4 [3];
  logic [2:0]         neg4;
  origin_t            o4;
  // stage 5: normalizing shift
  logic [55:0]        mag5 [3];
  logic [2:0]         neg5;
  logic [5:0]         sh5;
  origin_t            o5;
  // stage 6: truncated magnitudes
  logic [2:0][29:0]   mag6;
  logic [2:0]         neg6;
  origin_t            o6;
  // stage 7: squares
  logic [59:0]        sq [3];
  logic [2:0][29:0]   mag7;
  logic [2:0]         neg7;
  origin_t            o7;

  logic [55:0] orv;
  logic [5:0]  blen;
  logic [5:0]  sh_c;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[6:0], in_valid};
  end

  always_ff @(posedge clk) begin
    v[0] <= in_item.dx * $signed({1'b0, cfg.tan_half_fov});
    v[1] <= in_item.dy * $signed({1'b0, cfg.tan_half_fov});
    v[2] <= -$signed({7'd0, in_item.h, 19'd0});
    o1   <= in_item.org;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i][j] <= v[i] * $signed(cfg.rot[i][16*j +: 16]);
      end
    end
    o2 <= o1;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      u[j] <= 57'(p[0][j]) + 57'(p[1][j]) + 57'(p[2][j]);
    end
    o3 <= o2;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      neg4[j] <= u[j][56];
      mag4[j] <= u[j][56] ? 56'(-u[j]) : u[j][55:0];
    end
    o4 <= o3;
  end

  // bit length of the largest magnitude equals that of the OR of all three
  always_comb begin
    orv  = mag4[0] | mag4[1] | mag4[2];
    blen = '0;
    for (int b = 0; b < 56; b++) begin
      if (orv[b]) blen = 6'(b + 1);
    end
    sh_c = (blen > 6'd30) ? blen - 6'd30 : 6'd0;
  end

  always_ff @(posedge clk) begin
    mag5 <= mag4;
    neg5 <= neg4;
    sh5  <= sh_c;
    o5   <= o4;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      mag6[j] <= 30'(mag5[j] >> sh5);
    end
    neg6 <= neg5;
    o6   <= o5;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq[j] <= mag6[j] * mag6[j];
    end
    mag7 <= mag6;
    neg7 <= neg6;
    o7   <= o6;
  end

  always_ff @(posedge clk) begin
    out_item.sum <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
    out_item.mag <= mag7;
    out_item.neg <= neg7;
    out_item.org <= o7;
  end

  assign out_valid = vld[7];

endmodule

/* rtl/core/crg_norm.sv */
// Datapath part two: pipelined square root and three pipelined dividers.
module crg_norm import crg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dir_item_t        in_item,
  output logic             out_valid,
  output origin_t          out_org,
  output logic [2:0][15:0] out_dir
);

  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 15;

  // square root pipeline, one result bit per stage
  logic             sv  [SQ_STEPS+1];
  logic [61:0]      sn  [SQ_STEPS+1];
  logic [61:0]      sr  [SQ_STEPS+1];
  logic [2:0][29:0] smg [SQ_STEPS+1];
  logic [2:0]       sng [SQ_STEPS+1];
  origin_t          sor [SQ_STEPS+1];

  assign sv[0]  = in_valid;
  assign sn[0]  = in_item.sum;
  assign sr[0]  = '0;
  assign smg[0] = in_item.mag;
  assign sng[0] = in_item.neg;
  assign sor[0] = in_item.org;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (60 - 2*k);
    logic [62:0] trial;
    assign trial = {1'b0, sr[k]} + {1'b0, BIT};
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else     sv[k+1] <= sv[k];
    end
    always_ff @(posedge clk) begin
      if ({1'b0, sn[k]} >= trial) begin
        sn[k+1] <= sn[k] - trial[61:0];
        sr[k+1] <= (sr[k] >> 1) + BIT;
      end else begin
        sn[k+1] <= sn[k];
        sr[k+1] <= sr[k] >> 1;
      end
      smg[k+1] <= smg[k];
      sng[k+1] <= sng[k];
      sor[k+1] <= sor[k];
    end
  end

  // divider pipelines: q = (mag*16384 + len/2) / len
  logic             dv  [DIV_STEPS+1];
  logic [30:0]      dl  [DIV_STEPS+1];
  logic [2:0][30:0] dr  [DIV_STEPS+1];
  logic [2:0][14:0] dlo [DIV_STEPS+1];
  logic [2:0][14:0] dq  [DIV_STEPS+1];
  logic [2:0]       dng [DIV_STEPS+1];
  origin_t          dor [DIV_STEPS+1];

  logic [30:0] len;
  logic [44:0] num [3];

  assign len = sr[SQ_STEPS][30:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j] = {1'b0, smg[SQ_STEPS][j], 14'd0} + {15'd0, len[30:1]};
    end
  end

  // mag never exceeds len, so the top part starts below the divisor
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= sv[SQ_STEPS];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dr[0][j]  <= {1'b0, num[j][44:15]};
      dlo[0][j] <= num[j][14:0];
    end
    dq[0]  <= '0;
    dl[0]  <= len;
    dng[0] <= sng[SQ_STEPS];
    dor[0] <= sor[SQ_STEPS];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - k;
    logic [31:0] rem2 [3];
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        rem2[j] = {dr[k][j], dlo[k][j][QB]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
    end
    always_ff @(posedge clk) begin
      for (int j = 0; j < 3; j++) begin
        if (rem2[j] >= {1'b0, dl[k]}) begin
          dr[k+1][j] <= 31'(rem2[j] - {1'b0, dl[k]});
          dq[k+1][j] <= dq[k][j] | (15'd1 << QB);
        end else begin
          dr[k+1][j] <= rem2[j][30:0];
          dq[k+1][j] <= dq[k][j];
        end
      end
      dlo[k+1] <= dlo[k];
      dl[k+1]  <= dl[k];
      dng[k+1] <= dng[k];
      dor[k+1] <= dor[k];
    end
  end

  logic [14:0] qf [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qf[j] = dq[DIV_STEPS][j];
      if (dl[DIV_STEPS] == 31'd0) qf[j] = '0;
      else if (qf[j] > DIR_ONE)   qf[j] = DIR_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= dv[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      out_dir[j] <= dng[DIV_STEPS][j] ? 16'(-{1'b0, qf[j]}) : {1'b0, qf[j]};
    end
    out_org <= dor[DIV_STEPS];
  end

endmodule

/* rtl/core/camera_ray_generator.sv */
// Top level of the pinhole camera primary ray generator.
//
//   channel   | signals                                     | handshake
//   ----------+---------------------------------------------+-----------------------
//   sample in | pixel_row, pixel_col, origin_x/y/z          | start & !busy
//   ray out   | ray_origin_x/y/z, dir_x/y/z                 | done, one cycle
//   config    | psel, penable, pwrite, paddr, pwdata, prdata| APB, pready always 1
//
// One item per cycle; from the accepting edge to the result an item passes the front-end
// register, the queue, the transform pipeline, the square root pipeline, the divider
// pipelines and the output register.
// Synchronous active-high reset clears all valid flags and loads register defaults.
// The output has no stall and the back end drains the queue every cycle, so busy
// stays low.
module camera_ray_generator import crg_pkg::*; #(
  parameter int IMAGE_DIM_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         pixel_row,
  input  logic [15:0]         pixel_col,
  input  logic signed [23:0]  origin_x,
  input  logic signed [23:0]  origin_y,
  input  logic signed [23:0]  origin_z,
  output logic                done,
  output logic signed [23:0]  ray_origin_x,
  output logic signed [23:0]  ray_origin_y,
  output logic signed [23:0]  ray_origin_z,
  output logic signed [15:0]  dir_x,
  output logic signed [15:0]  dir_y,
  output logic signed [15:0]  dir_z,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t             cfg;
  origin_t          org_in;
  logic             take;
  logic             f_valid;
  front_item_t      f_item;
  logic             q_valid;
  front_item_t      q_item;
  logic             x_valid;
  dir_item_t        x_item;
  origin_t          n_org;
  logic [2:0][15:0] n_dir;

  assign take       = start & ~busy;
  assign org_in.x   = origin_x;
  assign org_in.y   = origin_y;
  assign org_in.z   = origin_z;

  crg_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  crg_front #(.IMAGE_DIM_BITS(IMAGE_DIM_BITS)) u_front (
    .clk(clk), .rst(rst), .take(take), .pixel_row(pixel_row), .pixel_col(pixel_col),
    .org(org_in), .cfg(cfg), .item_valid(f_valid), .item(f_item)
  );

  crg_fifo u_fifo (
    .clk(clk), .rst(rst), .push(f_valid), .push_item(f_item),
    .pop_valid(q_valid), .pop_item(q_item), .full(busy)
  );

  crg_xform u_xform (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_item(q_item), .cfg(cfg),
    .out_valid(x_valid), .out_item(x_item)
  );

  crg_norm u_norm (
    .clk(clk), .rst(rst), .in_valid(x_valid), .in_item(x_item),
    .out_valid(done), .out_org(n_org), .out_dir(n_dir)
  );

  assign ray_origin_x = n_org.x;
  assign ray_origin_y = n_org.y;
  assign ray_origin_z = n_org.z;
  assign dir_x        = n_dir[0];
  assign dir_y        = n_dir[1];
  assign dir_z        = n_dir[2];

endmodule

/* test/tb_camera_ray_generator.sv */
// Testbench for the camera ray generator: random and directed rays, scoreboard check.
`timescale 1ns / 1ps

module tb_camera_ray_generator;
  import crg_pkg::*;

  localparam int DIM_BITS = 12;
  localparam int LIMIT = 2000000;

  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
  } ray_t;

  class ray_scoreboard;
    ray_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note(ray_t r);
      pending.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check(ray_t r);
      ray_t e;
      if (pending.size() == 0) begin
        report("ray with no item outstanding", 1, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.ox !== e.ox) report("ray_origin_x", r.ox, e.ox);
      if (r.oy !== e.oy) report("ray_origin_y", r.oy, e.oy);
      if (r.oz !== e.oz) report("ray_origin_z", r.oz, e.oz);
      if (r.dx !== e.dx) report("dir_x", r.dx, e.dx);
      if (r.dy !== e.dy) report("dir_y", r.dy, e.dy);
      if (r.dz !== e.dz) report("dir_z", r.dz, e.dz);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic start = 0;
  logic busy, done, pready;
  logic [15:0] pixel_row = 0, pixel_col = 0;
  logic signed [23:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [23:0] ray_origin_x, ray_origin_y, ray_origin_z;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0, prdata;

  camera_ray_generator #(.IMAGE_DIM_BITS(DIM_BITS)) uut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  ray_scoreboard sb = new();
  logic [12:0] cfg_w = RST_IMAGE_WIDTH, cfg_h = RST_IMAGE_HEIGHT;
  logic [19:0] cfg_tan = RST_TAN_HALF_FOV;
  logic [47:0] cfg_rot[3] = '{RST_ROT_ROW0, RST_ROT_ROW1, RST_ROT_ROW2};
  int send_idle = 29;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      sb.check('{ray_origin_x, ray_origin_y, ray_origin_z, dir_x, dir_y, dir_z});
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("tb_camera_ray_generator NOT OK");
      $finish;
    end
  end

  function automatic longint dim_used(logic [12:0] raw);
    longint d = raw;
    if (d == 0) d = 1;
    if (d > (1 << DIM_BITS)) d = 1 << DIM_BITS;
    return d;
  endfunction

  function automatic longint usqrt(longint unsigned n);
    longint unsigned res = 0, bits = 64'd1 << 62;
    while (bits > n) bits >>= 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n -= res + bits;
        res = (res >> 1) + bits;
      end else res >>= 1;
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(logic [15:0] row, logic [15:0] col,
                                     logic signed [23:0] ox, oy, oz);
    ray_t r;
    longint w = dim_used(cfg_w), h = dim_used(cfg_h), t = cfg_tan;
    longint v[3], u;
    longint unsigned mag[3], mx = 0, sum = 0, len, q;
    logic neg[3];
    logic signed [15:0] dir[3];
    logic signed [15:0] m;
    int bl = 0, sh;
    v[0] = (longint'(col) - 8 * w) * t;
    v[1] = (8 * h - longint'(row)) * t;
    v[2] = -(8 * h * 65536);
    for (int j = 0; j < 3; j++) begin
      u = 0;
      for (int i = 0; i < 3; i++) begin
        m = cfg_rot[i][16*j +: 16];
        u += v[i] * longint'(m);
      end
      neg[j] = u < 0;
      mag[j] = neg[j] ? -u : u;
      if (mag[j] > mx) mx = mag[j];
    end
    while (bl < 64 && (mx >> bl) != 0) bl++;
    sh = bl > 30 ? bl - 30 : 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] >>= sh;
      sum += mag[j] * mag[j];
    end
    len = usqrt(sum);
    for (int j = 0; j < 3; j++) begin
      q = 0;
      if (len != 0) begin
        q = (mag[j] * 16384 + len / 2) / len;
        if (q > 16384) q = 16384;
      end
      dir[j] = 16'(neg[j] ? -q : q);
    end
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.dx = dir[0]; r.dy = dir[1]; r.dz = dir[2];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(idx) << 3; pwdata <= 64'(val);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_IMAGE_WIDTH:  cfg_w = val[12:0];
      REG_IMAGE_HEIGHT: cfg_h = val[12:0];
      REG_TAN_HALF_FOV: cfg_tan = val[19:0];
      REG_ROT_ROW0:     cfg_rot[0] = val;
      REG_ROT_ROW1:     cfg_rot[1] = val;
      REG_ROT_ROW2:     cfg_rot[2] = val;
      default: ;
    endcase
  endtask

  // stop sending, then settle: all rays back plus a margin
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // start stays high after an accepted item so the next one can follow at once
  task automatic send_ray(logic [15:0] row, logic [15:0] col,
                          logic signed [23:0] ox, oy, oz);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    pixel_row <= row; pixel_col <= col;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(trace_ray(row, col, ox, oy, oz));
  endtask

  function automatic logic [15:0] q214();
    case ($urandom_range(5))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h0000;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_rays(int n, logic [15:0] rmax, logic [15:0] cmax);
    logic [15:0] row, col;
    for (int k = 0; k < n; k++) begin
      row = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(rmax));
      col = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(cmax));
      send_ray(row, col, 24'($urandom), 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset settings: corners, center, far outside the image, origin extremes
    send_ray(0, 0, 24'sh7FFFFF, 24'sh800000, 0);
    send_ray(16'd7680, 16'd10240, -24'sd1, 24'sd1, 24'sh7FFFFF);
    send_ray(16'd3840, 16'd5120, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send_ray(16'hFFFF, 16'hFFFF, 24'h555555, 24'hAAAAAA, -24'sd1);
    send_ray(16'hFFFF, 0, 0, 0, 0);
    send_ray(0, 16'hFFFF, 24'hAAAAAA, 24'h555555, 24'sd1);
    drain();

    // zero dimensions, zero tangent
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_TAN_HALF_FOV, 0);
    send_ray(0, 0, 1, 2, 3);
    send_ray(16'hFFFF, 16'hFFFF, 4, 5, 6);
    drain();
    // oversized dimensions, largest tangent
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    write_reg(REG_TAN_HALF_FOV, 20'hFFFFF);
    send_ray(0, 0, 7, 8, 9);
    send_ray(16'hFFFF, 16'hFFFF, 10, 11, 12);
    send_ray(16'h8000, 16'h8000, 13, 14, 15);
    drain();
    // all-zero matrix gives a zero direction
    write_reg(REG_ROT_ROW0, 0);
    write_reg(REG_ROT_ROW1, 0);
    write_reg(REG_ROT_ROW2, 0);
    send_ray(100, 200, 16, 17, 18);
    send_ray(16'hFFFF, 0, 19, 20, 21);
    drain();
    // extreme matrix entries
    write_reg(REG_ROT_ROW0, 48'h8000_7FFF_8000);
    write_reg(REG_ROT_ROW1, 48'h7FFF_8000_7FFF);
    write_reg(REG_ROT_ROW2, 48'hFFFF_FFFF_FFFF);
    send_ray(0, 16'hFFFF, 22, 23, 24);
    send_ray(16'hFFFF, 0, 25, 26, 27);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      logic [12:0] w, h;
      send_idle = phase < 3 ? 29 : (phase < 6 ? 88 : 0);
      w = (phase % 3 == 0) ? 13'($urandom_range(1, 64)) : 13'($urandom_range(8191));
      h = (phase % 3 == 1) ? 13'($urandom_range(1, 64)) : 13'($urandom_range(8191));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      write_reg(REG_TAN_HALF_FOV, 48'($urandom_range((1 << 20) - 1)));
      for (int i = 0; i < 3; i++)
        write_reg(REG_ROT_ROW0 + 3'(i), {q214(), q214(), q214()});
      random_rays(80, 16'(dim_used(h) * 16 - 1), 16'(dim_used(w) * 16 - 1));
      drain();
    end

    $display("covered %0d rays over directed corners and nine random settings",
             sb.checked);
    $display("dimension, tangent and matrix extremes included");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_camera_ray_generator OK");
    else
      $display("tb_camera_ray_generator NOT OK");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/crg_pkg.sv
rtl/core/crg_regs.sv
rtl/core/crg_front.sv
rtl/core/crg_fifo.sv
rtl/core/crg_xform.sv
rtl/core/crg_norm.sv
rtl/core/camera_ray_generator.sv
test/tb_camera_ray_generator.sv
